### hdl/bhm_pkg.sv
package bhm_pkg;

   localparam int NUM_CODES          = 256;
   localparam int CODE_BITS          = $clog2(NUM_CODES);
   localparam int MODE_COUNT_BITS    = 16;
   localparam int DEFAULT_COUNT_BITS = 16;

   localparam logic [CODE_BITS-1:0] END_CODE = '0;

   typedef struct packed {
      logic update;
      logic clear;
   } best_ctl_type;

endpackage

### hdl/bhm_count_ram.sv
module bhm_count_ram
   import bhm_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [CODE_BITS-1:0]  rd_addr,
   output logic [COUNT_BITS-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [CODE_BITS-1:0]  wr_addr,
   input  logic [COUNT_BITS-1:0] wr_data,
   input  logic                  clear_all
);

   logic [COUNT_BITS-1:0] count_mem_ff [NUM_CODES];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [CODE_BITS-1:0]  rd_addr_ff;
   logic [NUM_CODES-1:0]  valid_ff;
   logic [NUM_CODES-1:0]  valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= count_mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // entry not written since the last clear reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = valid_ff[rd_addr_ff] ? rd_data_ff : '0;

endmodule

### hdl/bhm_best_track.sv
module bhm_best_track
   import bhm_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  best_ctl_type          ctl,
   input  logic [CODE_BITS-1:0]  code,
   input  logic [COUNT_BITS-1:0] count,
   output logic [CODE_BITS-1:0]  best_char,
   output logic [COUNT_BITS-1:0] best_count
);

   logic [CODE_BITS-1:0]  best_char_ff;
   logic [CODE_BITS-1:0]  best_char_in;
   logic [COUNT_BITS-1:0] best_count_ff;
   logic [COUNT_BITS-1:0] best_count_in;
   logic                  take;

   // ties go to the lower code
   assign take = (count > best_count_ff) ||
                 ((count == best_count_ff) && (code < best_char_ff));

   always_comb begin
      best_char_in  = best_char_ff;
      best_count_in = best_count_ff;
      if (ctl.clear) begin
         best_char_in  = '0;
         best_count_in = '0;
      end else if (ctl.update && take) begin
         best_char_in  = code;
         best_count_in = count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_char_ff  <= '0;
         best_count_ff <= '0;
      end else begin
         best_char_ff  <= best_char_in;
         best_count_ff <= best_count_in;
      end
   end

   assign best_char  = best_char_ff;
   assign best_count = best_count_ff;

endmodule

### hdl/byte_histogram_mode.sv
// Throughput: one byte per cycle unless stalled, repeats too (write-back forwarding).
// A terminator's result is registered from the best tracker once the output is free.
// Per-byte path: registered counter RAM read, then increment, write-back and best update.
// Input stalls only while a finished result is held by a stalled output.
// Reset (synchronous): counters and best cleared through per-entry
// valid flags; no clearing pass, the block takes beats right after reset.
module byte_histogram_mode
   import bhm_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CODE_BITS-1:0]       req_char_code,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CODE_BITS-1:0]       rsp_mode_char,
   output logic [MODE_COUNT_BITS-1:0] rsp_mode_count
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                       s1_valid_ff, s1_valid_in;
   logic [CODE_BITS-1:0]       s1_code_ff, s1_code_in;
   logic                       fwd_valid_ff, fwd_valid_in;
   logic [CODE_BITS-1:0]       fwd_code_ff, fwd_code_in;
   logic [COUNT_BITS-1:0]      fwd_count_ff, fwd_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]       rsp_char_ff, rsp_char_in;
   logic [MODE_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic                  s1_term;
   logic                  s1_go;
   logic                  out_free;
   logic                  wr_en;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;
   logic [CODE_BITS-1:0]  best_char;
   logic [COUNT_BITS-1:0] best_count;
   best_ctl_type          best_ctl;

   assign s1_term   = (s1_code_ff == END_CODE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_term || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = s1_go && !s1_term;

   // the read issued when this byte was accepted misses the write made at that same edge
   assign cur_count = (fwd_valid_ff && (fwd_code_ff == s1_code_ff)) ? fwd_count_ff : rd_data;
   assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);

   assign best_ctl.update = wr_en;
   assign best_ctl.clear  = s1_go && s1_term;

   bhm_count_ram #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (req_char_code),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (s1_code_ff),
      .wr_data   (new_count),
      .clear_all (best_ctl.clear)
   );

   bhm_best_track #(
      .COUNT_BITS (COUNT_BITS)
   ) u_best_track (
      .clock      (clock),
      .reset      (reset),
      .ctl        (best_ctl),
      .code       (s1_code_ff),
      .count      (new_count),
      .best_char  (best_char),
      .best_count (best_count)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_go);
      s1_code_in   = accept ? req_char_code : s1_code_ff;
      fwd_valid_in = wr_en;
      fwd_code_in  = s1_code_ff;
      fwd_count_in = new_count;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      if (best_ctl.clear) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = best_char;
         rsp_count_in = MODE_COUNT_BITS'(best_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_code_ff   <= s1_code_in;
      fwd_code_ff  <= fwd_code_in;
      fwd_count_ff <= fwd_count_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_char  = rsp_char_ff;
   assign rsp_mode_count = rsp_count_ff;

   a_stall_only_on_term: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_term && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked terminator");

   a_term_gives_beat: assert property (@(posedge clock) disable iff (reset)
      best_ctl.clear |=> rsp_valid_ff)
      else $error("terminator left no result beat");

   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      best_ctl.clear |=> (best_count == '0) && (best_char == '0))
      else $error("best not cleared after terminator");

   a_fwd_matches_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept && (req_char_code == s1_code_ff)) |=>
         (fwd_valid_ff && (fwd_code_ff == s1_code_ff)))
      else $error("repeat of a code lost its forwarded count");

endmodule
